/* rtl/flex_pkg.sv */
// Shared types, constants and keyword tables for the formula lexer.
`default_nettype none

package flex_pkg;

  // Token length counter and string nesting depth, both saturating.
  localparam int LEN_W = 16;
  localparam logic [LEN_W-1:0] MAX_TOKEN_LENGTH = 16'hFFFF;
  localparam int DEPTH_W = 8;
  localparam logic [DEPTH_W-1:0] MAX_NEST_DEPTH = 8'hFF;

  // Reserved word table.
  localparam int NUM_KW = 10;
  localparam int KW_MAX_LEN = 9;
  localparam int KW_IDX_W = 4;

  // Result queue geometry.
  localparam int RBUF_DEPTH = 4;
  localparam int RBUF_AW = 2;
  localparam int RBUF_LW = 3;

  // Lexer modes: which kind of token is pending.
  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_NUM,
    M_LTGT,
    M_DOT,
    M_MINUS,
    M_BANG,
    M_SPACE,
    M_STR,
    M_COMMENT
  } lex_mode_t;

  // Token kinds.
  localparam logic [3:0] KIND_IDENT    = 4'd0;
  localparam logic [3:0] KIND_OP       = 4'd1;
  localparam logic [3:0] KIND_KEYWORD  = 4'd2;
  localparam logic [3:0] KIND_INTEGER  = 4'd3;
  localparam logic [3:0] KIND_DECIMAL  = 4'd4;
  localparam logic [3:0] KIND_STRING   = 4'd5;
  localparam logic [3:0] KIND_COMMENT  = 4'd6;
  localparam logic [3:0] KIND_SPACE    = 4'd7;
  localparam logic [3:0] KIND_EOL      = 4'd8;
  localparam logic [3:0] KIND_LSQUARE  = 4'd9;
  localparam logic [3:0] KIND_RSQUARE  = 4'd10;
  localparam logic [3:0] KIND_LPAREN   = 4'd11;
  localparam logic [3:0] KIND_RPAREN   = 4'd12;
  localparam logic [3:0] KIND_COMMA    = 4'd13;
  localparam logic [3:0] KIND_SEMI     = 4'd14;
  localparam logic [3:0] KIND_ARROW    = 4'd15;

  // Error codes.
  localparam logic [1:0] ERR_UNRECOGNISED  = 2'd0;
  localparam logic [1:0] ERR_MULTI_DOT     = 2'd1;
  localparam logic [1:0] ERR_OPEN_QUOTE    = 2'd2;
  localparam logic [1:0] ERR_OPEN_COMMENT  = 2'd3;

  // One result as it leaves the block.
  typedef struct packed {
    logic [3:0]       kind;
    logic [LEN_W-1:0] len;
    logic             err;
    logic [1:0]       code;
    logic             last;
  } lex_res_t;

  // Everything one byte produces: zero, one or two results.
  typedef struct packed {
    logic [1:0] count;
    lex_res_t   r0;
    lex_res_t   r1;
  } lex_step_t;

  // Word lengths, entry 0 in the lowest nibble.
  localparam logic [NUM_KW-1:0][3:0] KW_LEN = {
    4'd9, 4'd6, 4'd3, 4'd3, 4'd5, 4'd3, 4'd3, 4'd2, 4'd2, 4'd1
  };

  // Set where the word is a keyword, clear where it is an operator word.
  localparam logic [NUM_KW-1:0] KW_IS_KEYWORD = 10'b11_1100_0000;

  // Byte i of reserved word k, zero beyond its end.
  function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                         input logic [3:0] i);
    logic [0:KW_MAX_LEN-1][7:0] s;
    case (k)
      4'd0: s = {8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd1: s = {8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd2: s = {8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd3: s = {8'h61, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd4: s = {8'h6E, 8'h6F, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd5: s = {8'h77, 8'h68, 8'h65, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd6: s = {8'h64, 8'h65, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd7: s = {8'h77, 8'h66, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      4'd8: s = {8'h77, 8'h66, 8'h6C, 8'h65, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00};
      4'd9: s = {8'h66, 8'h75, 8'h6E, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h73};
      default: s = '0;
    endcase
    if (i < 4'(KW_MAX_LEN)) begin
      return s[i];
    end else begin
      return 8'h00;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/flex_core.sv */
// Lexer state and the per-byte transition that yields up to two results.
`default_nettype none

module flex_core
  import flex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] char_byte,
  input  logic       end_of_text,
  output lex_step_t  step
);

  lex_mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [NUM_KW-1:0]    cand_r, cand_nxt;
  logic                 dot_r, dot_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic                 lock_r, lock_nxt;

  lex_res_t ext_res, start_res, fin_res;
  logic     ext_v, start_v, fin_v;

  function automatic lex_res_t mk_tok(input logic [3:0] kind, input logic [LEN_W-1:0] len,
                                      input logic err, input logic [1:0] code);
    lex_res_t r;
    r.kind = kind;
    r.len  = len;
    r.err  = err;
    r.code = code;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic lex_res_t mk_err(input logic [1:0] code);
    return mk_tok(KIND_IDENT, '0, 1'b1, code);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len);
    return (len == MAX_TOKEN_LENGTH) ? len : len + LEN_W'(1);
  endfunction

  // Drop every candidate word whose byte at this position differs.
  function automatic logic [NUM_KW-1:0] kw_match(input logic [NUM_KW-1:0] cand,
                                                 input logic [LEN_W-1:0] pos,
                                                 input logic [7:0] c);
    logic [NUM_KW-1:0] keep;
    logic              in_word;
    keep = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      in_word = pos < LEN_W'(KW_LEN[k]);
      if (!(in_word && kw_char(KW_IDX_W'(k), pos[3:0]) == c)) begin
        keep[k] = 1'b0;
      end
    end
    return keep;
  endfunction

  // Identifier kind once it ends: a surviving word of exactly this length.
  function automatic logic [3:0] ident_kind(input logic [NUM_KW-1:0] cand,
                                            input logic [LEN_W-1:0] len);
    logic [3:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && len == LEN_W'(KW_LEN[k])) begin
        kind = KW_IS_KEYWORD[k] ? KIND_KEYWORD : KIND_OP;
      end
    end
    return kind;
  endfunction

  // Offer the byte to the pending token, start a new one, close at end of text.
  always_comb begin
    logic used;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    cand_nxt  = cand_r;
    dot_nxt   = dot_r;
    depth_nxt = depth_r;
    lock_nxt  = lock_r;
    ext_v     = 1'b0;
    start_v   = 1'b0;
    fin_v     = 1'b0;
    ext_res   = '0;
    start_res = '0;
    fin_res   = '0;
    used      = 1'b0;

    if (!lock_r) begin
      // Extend the pending token.
      unique case (mode_r)
        M_IDENT: begin
          if (is_alpha(char_byte)) begin
            cand_nxt = kw_match(cand_r, len_r, char_byte);
            len_nxt  = grow(len_r);
            used     = 1'b1;
          end else begin
            ext_v    = 1'b1;
            ext_res  = mk_tok(ident_kind(cand_r, len_r), len_r, 1'b0, ERR_UNRECOGNISED);
            mode_nxt = M_IDLE;
          end
        end
        M_NUM: begin
          if (is_digit(char_byte)) begin
            len_nxt = grow(len_r);
            used    = 1'b1;
          end else if (char_byte == 8'h2E) begin
            used = 1'b1;
            if (dot_r) begin
              ext_v    = 1'b1;
              ext_res  = mk_err(ERR_MULTI_DOT);
              lock_nxt = 1'b1;
              mode_nxt = M_IDLE;
            end else begin
              dot_nxt = 1'b1;
              len_nxt = grow(len_r);
            end
          end else begin
            ext_v    = 1'b1;
            ext_res  = mk_tok(dot_r ? KIND_DECIMAL : KIND_INTEGER, len_r, 1'b0,
                              ERR_UNRECOGNISED);
            mode_nxt = M_IDLE;
          end
        end
        M_LTGT: begin
          ext_v    = 1'b1;
          mode_nxt = M_IDLE;
          if (char_byte == 8'h3D) begin
            ext_res = mk_tok(KIND_OP, LEN_W'(2), 1'b0, ERR_UNRECOGNISED);
            used    = 1'b1;
          end else begin
            ext_res = mk_tok(KIND_OP, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
          end
        end
        M_DOT: begin
          ext_v    = 1'b1;
          mode_nxt = M_IDLE;
          if (char_byte == 8'h2B || char_byte == 8'h2D || char_byte == 8'h2A ||
              char_byte == 8'h2F || char_byte == 8'h2E) begin
            ext_res = mk_tok(KIND_OP, LEN_W'(2), 1'b0, ERR_UNRECOGNISED);
            used    = 1'b1;
          end else begin
            ext_res = mk_tok(KIND_OP, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
          end
        end
        M_MINUS: begin
          ext_v    = 1'b1;
          mode_nxt = M_IDLE;
          if (char_byte == 8'h3E) begin
            ext_res = mk_tok(KIND_ARROW, LEN_W'(2), 1'b0, ERR_UNRECOGNISED);
            used    = 1'b1;
          end else begin
            ext_res = mk_tok(KIND_OP, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
          end
        end
        M_BANG: begin
          ext_v    = 1'b1;
          mode_nxt = M_IDLE;
          used     = 1'b1;
          if (char_byte == 8'h3D) begin
            ext_res = mk_tok(KIND_OP, LEN_W'(2), 1'b0, ERR_UNRECOGNISED);
          end else begin
            ext_res  = mk_err(ERR_UNRECOGNISED);
            lock_nxt = 1'b1;
          end
        end
        M_SPACE: begin
          if (char_byte <= 8'h20 && char_byte != 8'h0A) begin
            len_nxt = grow(len_r);
            used    = 1'b1;
          end else begin
            ext_v    = 1'b1;
            ext_res  = mk_tok(KIND_SPACE, len_r, 1'b0, ERR_UNRECOGNISED);
            mode_nxt = M_IDLE;
          end
        end
        M_STR: begin
          used    = 1'b1;
          len_nxt = grow(len_r);
          if (char_byte == 8'h5B) begin
            if (depth_r != MAX_NEST_DEPTH) begin
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end else if (depth_r != '0 && char_byte == 8'h5D) begin
            depth_nxt = depth_r - DEPTH_W'(1);
          end else if (depth_r == '0 && char_byte == 8'h27) begin
            ext_v    = 1'b1;
            ext_res  = mk_tok(KIND_STRING, len_nxt, 1'b0, ERR_UNRECOGNISED);
            mode_nxt = M_IDLE;
          end
        end
        M_COMMENT: begin
          used    = 1'b1;
          len_nxt = grow(len_r);
          if (char_byte == 8'h23) begin
            ext_v    = 1'b1;
            ext_res  = mk_tok(KIND_COMMENT, len_nxt, 1'b0, ERR_UNRECOGNISED);
            mode_nxt = M_IDLE;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase

      // Start a token with a byte the pending token did not take.
      if (!used) begin
        len_nxt = LEN_W'(1);
        priority if (is_alpha(char_byte)) begin
          mode_nxt = M_IDENT;
          cand_nxt = kw_match('1, '0, char_byte);
        end else if (is_digit(char_byte)) begin
          mode_nxt = M_NUM;
          dot_nxt  = 1'b0;
        end else if (char_byte == 8'h0A) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_EOL, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else if (char_byte <= 8'h20) begin
          mode_nxt = M_SPACE;
        end else if (char_byte == 8'h3C || char_byte == 8'h3E) begin
          mode_nxt = M_LTGT;
        end else if (char_byte == 8'h2E) begin
          mode_nxt = M_DOT;
        end else if (char_byte == 8'h2D) begin
          mode_nxt = M_MINUS;
        end else if (char_byte == 8'h21) begin
          mode_nxt = M_BANG;
        end else if (char_byte == 8'h27) begin
          mode_nxt  = M_STR;
          depth_nxt = '0;
        end else if (char_byte == 8'h23) begin
          mode_nxt = M_COMMENT;
        end else if (char_byte == 8'h5E || char_byte == 8'h7E || char_byte == 8'h3D ||
                     char_byte == 8'h2B || char_byte == 8'h2A || char_byte == 8'h2F ||
                     char_byte == 8'h25) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_OP, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else if (char_byte == 8'h5B) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_LSQUARE, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else if (char_byte == 8'h5D) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_RSQUARE, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else if (char_byte == 8'h28) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_LPAREN, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else if (char_byte == 8'h29) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_RPAREN, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else if (char_byte == 8'h2C) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_COMMA, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else if (char_byte == 8'h3B) begin
          start_v   = 1'b1;
          start_res = mk_tok(KIND_SEMI, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
        end else begin
          start_v   = 1'b1;
          start_res = mk_err(ERR_UNRECOGNISED);
          lock_nxt  = 1'b1;
        end
        if (start_v) begin
          mode_nxt = M_IDLE;
        end
      end

      // Close whatever is still pending at the end of the expression.
      if (end_of_text && !lock_nxt) begin
        unique case (mode_nxt)
          M_IDENT: begin
            fin_v   = 1'b1;
            fin_res = mk_tok(ident_kind(cand_nxt, len_nxt), len_nxt, 1'b0, ERR_UNRECOGNISED);
          end
          M_NUM: begin
            fin_v   = 1'b1;
            fin_res = mk_tok(dot_nxt ? KIND_DECIMAL : KIND_INTEGER, len_nxt, 1'b0,
                             ERR_UNRECOGNISED);
          end
          M_LTGT, M_DOT, M_MINUS: begin
            fin_v   = 1'b1;
            fin_res = mk_tok(KIND_OP, LEN_W'(1), 1'b0, ERR_UNRECOGNISED);
          end
          M_BANG: begin
            fin_v   = 1'b1;
            fin_res = mk_err(ERR_UNRECOGNISED);
          end
          M_SPACE: begin
            fin_v   = 1'b1;
            fin_res = mk_tok(KIND_SPACE, len_nxt, 1'b0, ERR_UNRECOGNISED);
          end
          M_STR: begin
            fin_v   = 1'b1;
            fin_res = mk_err(ERR_OPEN_QUOTE);
          end
          M_COMMENT: begin
            fin_v   = 1'b1;
            fin_res = mk_err(ERR_OPEN_COMMENT);
          end
          default: begin
            fin_v = 1'b0;
          end
        endcase
      end
    end

    // End of text always leaves a fresh expression, also out of the error lock.
    if (end_of_text) begin
      mode_nxt  = M_IDLE;
      len_nxt   = '0;
      cand_nxt  = '0;
      dot_nxt   = 1'b0;
      depth_nxt = '0;
      lock_nxt  = 1'b0;
    end
  end

  // Pack the results in order and flag the final one.
  always_comb begin
    step.count = 2'({1'b0, ext_v} + {1'b0, start_v} + {1'b0, fin_v});
    step.r0    = ext_v ? ext_res : (start_v ? start_res : fin_res);
    step.r1    = (ext_v && start_v) ? start_res : fin_res;
    step.r0.last = (step.count == 2'd1);
    step.r1.last = (step.count == 2'd2);
  end

  // State registers advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      len_r   <= '0;
      cand_r  <= '0;
      dot_r   <= 1'b0;
      depth_r <= '0;
      lock_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      cand_r  <= cand_nxt;
      dot_r   <= dot_nxt;
      depth_r <= depth_nxt;
      lock_r  <= lock_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/flex_rbuf.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle when popped.
`default_nettype none

module flex_rbuf
  import flex_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_en,
  input  lex_step_t          step,
  input  logic               pop,
  output logic [RBUF_LW-1:0] level,
  output lex_res_t           head
);

  lex_res_t            ent_r [RBUF_DEPTH];
  logic [RBUF_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [RBUF_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [RBUF_LW-1:0]  level_r, level_nxt;
  logic [RBUF_AW-1:0]  wr_ptr_p1;
  logic [RBUF_LW-1:0]  push_cnt;

  // Pointer and fill level arithmetic.
  always_comb begin
    wr_ptr_p1  = wr_ptr_r + RBUF_AW'(1);
    push_cnt   = push_en ? RBUF_LW'(step.count) : '0;
    wr_ptr_nxt = wr_ptr_r + push_cnt[RBUF_AW-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + RBUF_AW'(1) : rd_ptr_r;
    level_nxt  = level_r + push_cnt - RBUF_LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Result storage, written in request order.
  always_ff @(posedge clk) begin
    if (push_en && step.count != 2'd0) begin
      ent_r[wr_ptr_r] <= step.r0;
    end
    if (push_en && step.count == 2'd2) begin
      ent_r[wr_ptr_p1] <= step.r1;
    end
  end

  assign level = level_r;
  assign head  = ent_r[rd_ptr_r];

endmodule

`default_nettype wire

/* rtl/formula_lexer_unit.sv */
// Top level of the formula lexer: byte input channel, token result channel.
//
// Each input request carries one text byte and an end-of-text flag. The byte is
// lexed in the cycle it is accepted and yields zero, one or two result requests,
// the final one marked by out_last_of_run. Results are registered in a queue, so
// the first can appear in the cycle after its byte is accepted; results leave at
// one per cycle while out_stall is low. Bytes are taken at one per cycle while
// they yield at most one result each and out_stall is low; bytes that yield two
// results fill the four-entry result queue; it accepts a byte only while it has
// room for two more results, so in_stall rises when out_stall holds it full.
// A stalled result holds its fields until it is taken.
// After an error the lexer reports nothing until the byte carrying end of
// text, which also yields nothing; every end of text starts a fresh expression.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to
// idle with no pending token.
`default_nettype none

module formula_lexer_unit
  import flex_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char_byte,
  input  logic             in_end_of_text,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_token_kind,
  output logic [LEN_W-1:0] out_token_length,
  output logic             out_is_error,
  output logic [1:0]       out_error_code,
  output logic             out_last_of_run
);

  lex_step_t          step;
  lex_res_t           head;
  logic [RBUF_LW-1:0] level;
  logic               in_fire;
  logic               out_fire;

  // Handshakes.
  assign in_stall  = level > RBUF_LW'(RBUF_DEPTH - 2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = level != '0;
  assign out_fire  = out_valid && !out_stall;

  flex_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .char_byte   (in_char_byte),
    .end_of_text (in_end_of_text),
    .step        (step)
  );

  flex_rbuf u_rbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (in_fire),
    .step    (step),
    .pop     (out_fire),
    .level   (level),
    .head    (head)
  );

  // Result fields from the head of the queue.
  assign out_token_kind   = head.kind;
  assign out_token_length = head.len;
  assign out_is_error     = head.err;
  assign out_error_code   = head.code;
  assign out_last_of_run  = head.last;

`ifndef SYNTHESIS
  // The queue never holds more than it has room for.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= RBUF_LW'(RBUF_DEPTH))
    else $error("result queue overfilled");

  // An accepted byte that produces results makes the queue non-empty next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && step.count != 2'd0 |=> out_valid)
    else $error("accepted results not visible");

  // Error results carry the identifier kind and zero length.
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |-> out_token_kind == KIND_IDENT && out_token_length == '0)
    else $error("malformed error result");

  // A non-error result has error code zero.
  a_code_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_error |-> out_error_code == ERR_UNRECOGNISED)
    else $error("error code set on a token result");
`endif

endmodule

`default_nettype wire

/* verif/formula_lexer_unit_token_check.sv */
// Token predictor and scoreboard that watch both channels of the formula lexer.
`timescale 1ns / 100ps

module formula_lexer_unit_token_check
  import flex_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_char_byte,
  input  logic             in_end_of_text,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [3:0]       out_token_kind,
  input  logic [LEN_W-1:0] out_token_length,
  input  logic             out_is_error,
  input  logic [1:0]       out_error_code,
  input  logic             out_last_of_run,
  output int               mismatch_count,
  output int               tokens_awaited,
  output int               bytes_taken,
  output int               tokens_taken,
  output int               errors_taken
);

  localparam int WORD_COUNT = 10;
  // Words from this index on are keywords, the ones below are operator words.
  localparam int FIRST_KEYWORD = 6;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] NO_ERROR = 2'd0;

  // Lengths of the reserved words, word 0 in the lowest nibble.
  localparam logic [WORD_COUNT-1:0][3:0] WORD_LEN = {
    4'd9, 4'd6, 4'd3, 4'd3, 4'd5, 4'd3, 4'd3, 4'd2, 4'd2, 4'd1
  };

  // Predicted lexer state.
  lex_mode_t              mode;
  logic [WORD_COUNT-1:0]  word_hits;
  logic                   dot_seen;
  logic [DEPTH_W-1:0]     quote_depth;
  logic                   locked;
  logic [LEN_W-1:0]       tok_len;

  // Tokens produced by the byte being lexed, and those still to come out.
  lex_res_t step_tokens [2];
  int       step_count;
  lex_res_t expected_tokens [$];
  lex_res_t seen_token;
  lex_res_t want_token;

  // Byte pos of reserved word k; the words are held right-aligned.
  function automatic logic [7:0] word_char(int k, int pos);
    logic [71:0] text;
    case (k)
      0: text = "d";
      1: text = "or";
      2: text = "in";
      3: text = "and";
      4: text = "not";
      5: text = "where";
      6: text = "def";
      7: text = 72'h77666C;
      8: text = 72'h77666C656E64;
      9: text = "functions";
      default: text = '0;
    endcase
    return text[8 * (int'(WORD_LEN[k]) - 1 - pos) +: 8];
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic void clear_state();
    mode = M_IDLE;
    word_hits = '0;
    dot_seen = 1'b0;
    quote_depth = '0;
    locked = 1'b0;
    tok_len = '0;
  endfunction

  function automatic void record(logic [3:0] kind, logic [LEN_W-1:0] len, logic err,
                                 logic [1:0] code);
    if (step_count < 2) begin
      step_tokens[step_count] = '{kind: kind, len: len, err: err, code: code, last: 1'b0};
      step_count++;
    end
  endfunction

  function automatic void close_token(logic [3:0] kind, logic [LEN_W-1:0] len);
    record(kind, len, 1'b0, NO_ERROR);
    mode = M_IDLE;
  endfunction

  function automatic void raise(logic [1:0] code);
    record(KIND_IDENT, '0, 1'b1, code);
    locked = 1'b1;
    mode = M_IDLE;
  endfunction

  function automatic void lengthen();
    if (tok_len < MAX_TOKEN_LENGTH) begin
      tok_len++;
    end
  endfunction

  // Drop every reserved word whose byte at pos differs from c.
  function automatic void narrow_words(logic [LEN_W-1:0] pos, logic [7:0] c);
    for (int k = 0; k < WORD_COUNT; k++) begin
      if (word_hits[k] && !(pos < WORD_LEN[k] && word_char(k, int'(pos)) == c)) begin
        word_hits[k] = 1'b0;
      end
    end
  endfunction

  function automatic void close_ident();
    logic [3:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < WORD_COUNT; k++) begin
      if (word_hits[k] && tok_len == LEN_W'(WORD_LEN[k])) begin
        kind = (k >= FIRST_KEYWORD) ? KIND_KEYWORD : KIND_OP;
      end
    end
    close_token(kind, tok_len);
  endfunction

  // Work out the tokens that one byte request completes and queue them.
  function automatic void lex_byte(logic [7:0] c, logic last);
    logic consumed;
    step_count = 0;
    consumed = 1'b0;
    // After an error everything up to the end of text is swallowed.
    if (locked) begin
      if (last) begin
        clear_state();
      end
      return;
    end
    // Offer the byte to the pending token first.
    case (mode)
      M_IDENT: begin
        if (is_letter(c)) begin
          narrow_words(tok_len, c);
          lengthen();
          consumed = 1'b1;
        end else begin
          close_ident();
        end
      end
      M_NUM: begin
        if (c >= "0" && c <= "9") begin
          lengthen();
          consumed = 1'b1;
        end else if (c == ".") begin
          consumed = 1'b1;
          if (dot_seen) begin
            raise(ERR_MULTI_DOT);
          end else begin
            dot_seen = 1'b1;
            lengthen();
          end
        end else begin
          close_token(dot_seen ? KIND_DECIMAL : KIND_INTEGER, tok_len);
        end
      end
      M_LTGT: begin
        if (c == "=") begin
          close_token(KIND_OP, 2);
          consumed = 1'b1;
        end else begin
          close_token(KIND_OP, 1);
        end
      end
      M_DOT: begin
        if (c == "+" || c == "-" || c == "*" || c == "/" || c == ".") begin
          close_token(KIND_OP, 2);
          consumed = 1'b1;
        end else begin
          close_token(KIND_OP, 1);
        end
      end
      M_MINUS: begin
        if (c == ">") begin
          close_token(KIND_ARROW, 2);
          consumed = 1'b1;
        end else begin
          close_token(KIND_OP, 1);
        end
      end
      M_BANG: begin
        consumed = 1'b1;
        if (c == "=") begin
          close_token(KIND_OP, 2);
        end else begin
          raise(ERR_UNRECOGNISED);
        end
      end
      M_SPACE: begin
        if (c <= " " && c != "\n") begin
          lengthen();
          consumed = 1'b1;
        end else begin
          close_token(KIND_SPACE, tok_len);
        end
      end
      M_STR: begin
        // Brackets nest inside a string; only a quote at depth zero closes it.
        consumed = 1'b1;
        lengthen();
        if (c == "[") begin
          if (quote_depth < MAX_NEST_DEPTH) begin
            quote_depth++;
          end
        end else if (quote_depth != 0 && c == "]") begin
          quote_depth--;
        end else if (quote_depth == 0 && c == "'") begin
          close_token(KIND_STRING, tok_len);
        end
      end
      M_COMMENT: begin
        consumed = 1'b1;
        lengthen();
        if (c == "#") begin
          close_token(KIND_COMMENT, tok_len);
        end
      end
      default: begin
        mode = M_IDLE;
      end
    endcase
    // A byte that the pending token did not take starts a token of its own.
    if (!consumed && !locked) begin
      tok_len = 1;
      if (is_letter(c)) begin
        mode = M_IDENT;
        word_hits = '1;
        narrow_words('0, c);
      end else if (c >= "0" && c <= "9") begin
        mode = M_NUM;
        dot_seen = 1'b0;
      end else if (c == "\n") begin
        close_token(KIND_EOL, 1);
      end else if (c <= " ") begin
        mode = M_SPACE;
      end else begin
        case (c)
          "<", ">": mode = M_LTGT;
          ".": mode = M_DOT;
          "-": mode = M_MINUS;
          "!": mode = M_BANG;
          "'": begin
            mode = M_STR;
            quote_depth = '0;
          end
          "#": mode = M_COMMENT;
          "^", "~", "=", "+", "*", "/", "%": close_token(KIND_OP, 1);
          "[": close_token(KIND_LSQUARE, 1);
          "]": close_token(KIND_RSQUARE, 1);
          "(": close_token(KIND_LPAREN, 1);
          ")": close_token(KIND_RPAREN, 1);
          ",": close_token(KIND_COMMA, 1);
          ";": close_token(KIND_SEMI, 1);
          default: raise(ERR_UNRECOGNISED);
        endcase
      end
    end
    // End of text closes whatever is pending and starts a fresh expression.
    if (last) begin
      if (!locked) begin
        case (mode)
          M_IDENT: close_ident();
          M_NUM: close_token(dot_seen ? KIND_DECIMAL : KIND_INTEGER, tok_len);
          M_LTGT, M_DOT, M_MINUS: close_token(KIND_OP, 1);
          M_BANG: raise(ERR_UNRECOGNISED);
          M_SPACE: close_token(KIND_SPACE, tok_len);
          M_STR: raise(ERR_OPEN_QUOTE);
          M_COMMENT: raise(ERR_OPEN_COMMENT);
          default: ;
        endcase
      end
      clear_state();
    end
    if (step_count > 0) begin
      step_tokens[step_count - 1].last = 1'b1;
    end
    for (int i = 0; i < step_count; i++) begin
      expected_tokens.push_back(step_tokens[i]);
    end
  endfunction

  // Compare each token taken from the block, then predict from each byte taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_tokens.delete();
      mismatch_count = 0;
      bytes_taken = 0;
      tokens_taken = 0;
      errors_taken = 0;
    end else begin
      if (out_valid && !out_stall) begin
        tokens_taken++;
        if (out_is_error) begin
          errors_taken++;
        end
        seen_token = '{kind: out_token_kind, len: out_token_length, err: out_is_error,
                       code: out_error_code, last: out_last_of_run};
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: token kind %0d length %0d error %0b code %0d last %0b arrived unexpected",
                     $time, seen_token.kind, seen_token.len, seen_token.err, seen_token.code,
                     seen_token.last);
          end
        end else begin
          want_token = expected_tokens.pop_front();
          if (seen_token !== want_token) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: token mismatch, expected kind %0d length %0d error %0b code %0d last %0b",
                       $time, want_token.kind, want_token.len, want_token.err, want_token.code,
                       want_token.last);
              $display("%0t:                   actual kind %0d length %0d error %0b code %0d last %0b",
                       $time, seen_token.kind, seen_token.len, seen_token.err, seen_token.code,
                       seen_token.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        bytes_taken++;
        lex_byte(in_char_byte, in_end_of_text);
      end
    end
    tokens_awaited <= expected_tokens.size();
  end

endmodule

/* verif/formula_lexer_unit_tb.sv */
// Stimulus, clock, reset and final verdict for the formula lexer testbench.
`timescale 1ns / 100ps

module formula_lexer_unit_tb
  import flex_pkg::*;
();

  localparam int RANDOM_BYTES = 350;
  localparam int CALM_FROM = 100;
  localparam int CALM_TO = 250;
  localparam int DEEP_NEST = 260;
  localparam int IDLE_PERCENT = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 1000000;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_char_byte = 8'h00;
  logic             in_end_of_text = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [3:0]       out_token_kind;
  logic [LEN_W-1:0] out_token_length;
  logic             out_is_error;
  logic [1:0]       out_error_code;
  logic             out_last_of_run;

  int mismatch_count;
  int tokens_awaited;
  int bytes_taken;
  int tokens_taken;
  int errors_taken;

  // While calm is set neither side idles.
  bit         calm = 1'b0;
  int         cycle_count = 0;
  int         sent_bytes = 0;
  int         text_sets = 0;
  logic [7:0] text_q [$];
  string      lang;
  string      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

  formula_lexer_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_length (out_token_length),
    .out_is_error     (out_is_error),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

  formula_lexer_unit_token_check u_token_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_length (out_token_length),
    .out_is_error     (out_is_error),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run),
    .mismatch_count   (mismatch_count),
    .tokens_awaited   (tokens_awaited),
    .bytes_taken      (bytes_taken),
    .tokens_taken     (tokens_taken),
    .errors_taken     (errors_taken)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiving side: stalls at random outside the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d tokens still awaited",
               cycle_count, tokens_awaited);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one byte request and hold it until it is taken.
  task automatic send_byte(input logic [7:0] value, input logic last);
    logic took;
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= value;
    in_end_of_text <= last;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sent_bytes++;
  endtask

  // Send the gathered text as one expression, end of text on its last byte.
  task automatic send_text();
    foreach (text_q[i]) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
    text_sets++;
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endfunction

  task automatic send_str(string s);
    add_str(s);
    send_text();
  endtask

  // Hold the sender back until every predicted token has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_awaited != 0) begin
      @(posedge clk);
    end
  endtask

  // Append one plausible token with random content.
  function automatic void add_random_token();
    int         n;
    int         depth;
    string      pick;
    logic [7:0] b;
    case ($urandom_range(0, 12))
      0, 1: begin
        repeat ($urandom_range(1, 7)) begin
          text_q.push_back(letters[$urandom_range(0, letters.len() - 1)]);
        end
      end
      2, 3: begin
        // Reserved words, sometimes cut short or run on.
        case ($urandom_range(0, 9))
          0: pick = "d";
          1: pick = "or";
          2: pick = "in";
          3: pick = "and";
          4: pick = "not";
          5: pick = "where";
          6: pick = "def";
          7: pick = lang;
          8: pick = {lang, "end"};
          default: pick = "functions";
        endcase
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, pick.len()) : pick.len();
        for (int i = 0; i < n; i++) begin
          text_q.push_back(pick[i]);
        end
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(letters[$urandom_range(0, letters.len() - 1)]);
        end
      end
      4: begin
        repeat ($urandom_range(1, 6)) begin
          text_q.push_back("0" + 8'($urandom_range(0, 9)));
        end
      end
      5: begin
        repeat ($urandom_range(1, 3)) begin
          text_q.push_back("0" + 8'($urandom_range(0, 9)));
        end
        text_q.push_back(".");
        repeat ($urandom_range(0, 3)) begin
          text_q.push_back("0" + 8'($urandom_range(0, 9)));
        end
      end
      6: begin
        case ($urandom_range(0, 19))
          0: add_str("<=");
          1: add_str(">=");
          2: add_str("!=");
          3: add_str(".+");
          4: add_str(".-");
          5: add_str(".*");
          6: add_str("./");
          7: add_str("..");
          8: add_str("->");
          9: add_str("-");
          10: add_str(".");
          11: add_str("<");
          12: add_str(">");
          13: add_str("^");
          14: add_str("~");
          15: add_str("=");
          16: add_str("+");
          17: add_str("*");
          18: add_str("/");
          default: add_str("%");
        endcase
      end
      7: begin
        pick = "[](),;";
        text_q.push_back(pick[$urandom_range(0, pick.len() - 1)]);
      end
      8: begin
        // Quoted string with balanced brackets and bytes of any other value.
        text_q.push_back("'");
        depth = 0;
        repeat ($urandom_range(0, 10)) begin
          n = $urandom_range(0, 99);
          if (n < 15) begin
            text_q.push_back("[");
            depth++;
          end else if (n < 30 && depth > 0) begin
            text_q.push_back("]");
            depth--;
          end else begin
            do begin
              b = 8'($urandom_range(0, 255));
            end while (b == "'" || b == "[" || b == "]");
            text_q.push_back(b);
          end
        end
        repeat (depth) begin
          text_q.push_back("]");
        end
        text_q.push_back("'");
      end
      9: begin
        text_q.push_back("#");
        repeat ($urandom_range(0, 10)) begin
          do begin
            b = 8'($urandom_range(0, 255));
          end while (b == "#");
          text_q.push_back(b);
        end
        text_q.push_back("#");
      end
      10: begin
        repeat ($urandom_range(1, 4)) begin
          do begin
            b = 8'($urandom_range(0, 32));
          end while (b == "\n");
          text_q.push_back(b);
        end
      end
      11: text_q.push_back("\n");
      default: text_q.push_back(" ");
    endcase
  endfunction

  initial begin
    int random_start;
    bit drained_mid;

    lang = $sformatf("%c%c%c", 8'h77, 8'h66, 8'h6C);
    drained_mid = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reserved words, every operator and each error case.
    send_str("where d or in and not def functions nots wher _a Zz9");
    send_str({lang, " ", lang, "end ", lang, "e functionsx D"});
    send_str("12 3.5 7. .5 0.");
    send_str("1.2.3 x y");
    send_str("<= >= < > <x .+ .- .* ./ .. .a -> - -1 != = ^ ~ + * / %");
    send_str("[]( ),;");
    send_str("'ab[c]d'x'[[y]]'");
    send_str("'unclosed [text'");
    send_str("#note# a\t\013\n b");
    send_str("#open");
    send_str("a!");
    send_str("!x y");
    send_str("a$b");
    send_str("\n");
    send_str("x\n");
    send_str("ab(");
    send_str("!");
    text_q.push_back("k");
    text_q.push_back(8'h00);
    text_q.push_back(8'h20);
    text_q.push_back(8'h7F);
    send_text();
    text_q.push_back(8'h80);
    send_text();
    text_q.push_back("q");
    text_q.push_back(8'hFF);
    send_text();
    text_q.push_back("'");
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    text_q.push_back("'");
    send_text();
    wait_drained();

    // Random expressions: mostly well formed, some noise and cut-off endings.
    random_start = sent_bytes;
    while (sent_bytes - random_start < RANDOM_BYTES) begin
      calm = (sent_bytes - random_start >= CALM_FROM) && (sent_bytes - random_start < CALM_TO);
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 99) < 3) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
        add_random_token();
        if ($urandom_range(0, 1) == 1) begin
          text_q.push_back(" ");
        end
      end
      case ($urandom_range(0, 24))
        0: text_q.push_back("'");
        1: text_q.push_back("#");
        2: text_q.push_back("!");
        3: add_str("7.1.");
        default: ;
      endcase
      send_text();
      if (!drained_mid && sent_bytes - random_start > RANDOM_BYTES / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
    end
    calm = 1'b0;
    wait_drained();

    // A string nested deeper than the depth counter holds.
    text_q.push_back("'");
    repeat (DEEP_NEST) text_q.push_back("[");
    repeat (int'(MAX_NEST_DEPTH)) text_q.push_back("]");
    add_str("'x");
    send_text();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Lexed %0d bytes in %0d expressions; %0d tokens checked, %0d of them errors.",
             bytes_taken, text_sets, tokens_taken, errors_taken);
    $display("Covered reserved words, numbers, operators, nested strings, comments and depth limit.");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
